// File: hw/rtl/tbtp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, character codes and controller/datapath interface types
// for the tagged box text parser. No dependencies.
package tbtp_pkg;

   localparam int TEXT_MAX    = 32;
   localparam int MAX_RESULTS = 32;
   localparam int LEN_W       = $clog2(TEXT_MAX + 1);
   localparam int ADDR_W      = $clog2(TEXT_MAX);

   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 16;
   localparam int COORD_W   = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 1'd1;

   localparam logic [CSR_W-1:0] SCREEN_WIDTH_RST  = 16'd1920;
   localparam logic [CSR_W-1:0] SCREEN_HEIGHT_RST = 16'd1080;

   localparam logic KIND_LABEL = 1'b0;
   localparam logic KIND_BOX   = 1'b1;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [23:0] TAG_REF  = "ref";
   localparam logic [23:0] TAG_BOX  = "box";
   localparam logic [31:0] TAG_EREF = "/ref";
   localparam logic [31:0] TAG_EBOX = "/box";

   // floor(p / 1000) == (p * RECIP_M) >> RECIP_SH for any 32-bit p
   localparam int          RECIP_M_W = 29;
   localparam logic [RECIP_M_W-1:0] RECIP_M = 29'd274877907;
   localparam int          RECIP_SH  = 38;

   typedef struct packed {
      logic store_byte;
      logic clr_buf;
      logic init_walk;
      logic parse_step;
      logic feed;
      logic sc_mul;
      logic sc_div;
      logic load_box;
      logic load_lbl;
   } cmd_type;

   typedef struct packed {
      logic is_lt;
      logic is_gt;
      logic buf_empty;
      logic tag_hit;
      logic group_nz;
      logic group_full;
      logic walk_end;
      logic parse_go;
      logic sc_last;
      logic lbl_last;
      logic out_free;
   } sts_type;

endpackage

// File: hw/rtl/tbtp_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the tagged box text parser.
// Depends on tbtp_pkg; drives the datapath through cmd_type, reads sts_type.
module tbtp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tbtp_pkg::sts_type sts,
   output tbtp_pkg::cmd_type cmd
);
   import tbtp_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_PARSE_RD = 9'b000000010,
      ST_PARSE_EV = 9'b000000100,
      ST_FEED     = 9'b000001000,
      ST_SC_MUL   = 9'b000010000,
      ST_SC_DIV   = 9'b000100000,
      ST_BOX_OUT  = 9'b001000000,
      ST_LBL_RD   = 9'b010000000,
      ST_LBL_OUT  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (sts.is_lt) begin
                  if (!sts.buf_empty) begin
                     cmd.init_walk = 1'b1;
                     state_in = sts.group_nz ? ST_FEED : ST_LBL_RD;
                  end
               end else if (sts.is_gt) begin
                  if (sts.tag_hit) begin
                     cmd.clr_buf = 1'b1;
                  end else begin
                     cmd.init_walk = 1'b1;
                     state_in = ST_PARSE_RD;
                  end
               end else begin
                  cmd.store_byte = 1'b1;
               end
            end
         end
         ST_PARSE_RD: begin
            state_in = sts.walk_end ? ST_FEED : ST_PARSE_EV;
         end
         ST_PARSE_EV: begin
            if (sts.parse_go) begin
               cmd.parse_step = 1'b1;
               state_in = ST_PARSE_RD;
            end else begin
               state_in = ST_FEED;
            end
         end
         ST_FEED: begin
            cmd.feed    = 1'b1;
            cmd.clr_buf = 1'b1;
            state_in = sts.group_full ? ST_SC_MUL : ST_IDLE;
         end
         ST_SC_MUL: begin
            cmd.sc_mul = 1'b1;
            state_in = ST_SC_DIV;
         end
         ST_SC_DIV: begin
            cmd.sc_div = 1'b1;
            state_in = sts.sc_last ? ST_BOX_OUT : ST_SC_MUL;
         end
         ST_BOX_OUT: begin
            if (sts.out_free) begin
               cmd.load_box = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_LBL_RD: begin
            state_in = ST_LBL_OUT;
         end
         ST_LBL_OUT: begin
            if (sts.out_free) begin
               cmd.load_lbl = 1'b1;
               if (sts.lbl_last) begin
                  cmd.clr_buf = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_LBL_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/tbtp_dp.sv
`timescale 1ns / 1ps
// Datapath of the tagged box text parser: text buffer, number parser,
// coordinate holding, scaling and result register. Depends on tbtp_pkg.
module tbtp_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  tbtp_pkg::cmd_type                  cmd,
   output tbtp_pkg::sts_type                  sts,
   input  logic [7:0]                         req_in_byte,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tbtp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tbtp_pkg::CSR_W-1:0]         csr_wdata,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_kind,
   output logic [7:0]                         rsp_label_byte,
   output logic                               rsp_label_truncated,
   output logic                               rsp_last_of_run,
   output logic [tbtp_pkg::COORD_W-1:0]       rsp_point1_x,
   output logic [tbtp_pkg::COORD_W-1:0]       rsp_point1_y,
   output logic [tbtp_pkg::COORD_W-1:0]       rsp_point2_x,
   output logic [tbtp_pkg::COORD_W-1:0]       rsp_point2_y
);
   import tbtp_pkg::*;

   localparam int RP_W = COORD_W + RECIP_M_W;

   logic [7:0]         text_mem [TEXT_MAX];
   logic [7:0]         rd_data_ff;
   logic [7:0]         head_ff [4];

   logic [LEN_W-1:0]   len_ff, len_in;
   logic               ovf_ff, ovf_in;
   logic [1:0]         group_ff, group_in;
   logic [1:0]         sc_ff, sc_in;
   logic [CSR_W-1:0]   width_ff, width_in;
   logic [CSR_W-1:0]   height_ff, height_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic [COORD_W-1:0] acc_ff, acc_in;
   logic               neg_ff, neg_in;
   logic               phase_ff, phase_in;
   logic [COORD_W-1:0] prod_ff, prod_in;
   logic [COORD_W-1:0] held_ff [4];
   logic [COORD_W-1:0] held_in [4];
   logic [COORD_W-1:0] pt_ff [4];
   logic [COORD_W-1:0] pt_in [4];

   logic               kind_ff, kind_in;
   logic [7:0]         lbyte_ff, lbyte_in;
   logic               trunc_ff, trunc_in;
   logic               last_ff, last_in;
   logic [COORD_W-1:0] p1x_ff, p1x_in, p1y_ff, p1y_in, p2x_ff, p2x_in, p2y_ff, p2y_in;

   logic               full;
   logic               is_ws, is_sign, is_dig;
   logic [3:0]         dig_val;
   logic [COORD_W-1:0] coord_val;
   logic [CSR_W-1:0]   scale_size;
   logic [RP_W-1:0]    recip_prod;
   logic               trunc_flag;

   assign csr_ready = 1'b1;
   assign full      = (int'(len_ff) == TEXT_MAX);

   assign is_ws   = (rd_data_ff == CH_SPACE) || (rd_data_ff >= CH_TAB && rd_data_ff <= CH_CR);
   assign is_sign = (rd_data_ff == CH_PLUS) || (rd_data_ff == CH_MINUS);
   assign is_dig  = (rd_data_ff >= CH_ZERO) && (rd_data_ff <= CH_NINE);
   assign dig_val = 4'(rd_data_ff - CH_ZERO);

   assign coord_val  = neg_ff ? (COORD_W'(0) - acc_ff) : acc_ff;
   assign scale_size = sc_ff[0] ? height_ff : width_ff;
   assign recip_prod = RP_W'(prod_ff) * RP_W'(RECIP_M);
   assign trunc_flag = ovf_ff || (int'(len_ff) > MAX_RESULTS);

   always_comb begin
      sts            = '0;
      sts.is_lt      = (req_in_byte == CH_LT);
      sts.is_gt      = (req_in_byte == CH_GT);
      sts.buf_empty  = (len_ff == '0);
      sts.tag_hit    = !ovf_ff &&
                       ((int'(len_ff) == 3 && ({head_ff[0], head_ff[1], head_ff[2]} == TAG_REF ||
                                               {head_ff[0], head_ff[1], head_ff[2]} == TAG_BOX)) ||
                        (int'(len_ff) == 4 &&
                         ({head_ff[0], head_ff[1], head_ff[2], head_ff[3]} == TAG_EREF ||
                          {head_ff[0], head_ff[1], head_ff[2], head_ff[3]} == TAG_EBOX)));
      sts.group_nz   = (group_ff != 2'd0);
      sts.group_full = (group_ff == 2'd3);
      sts.walk_end   = (idx_ff == len_ff);
      sts.parse_go   = phase_ff ? is_dig : (is_ws || is_sign || is_dig);
      sts.sc_last    = (sc_ff == 2'd3);
      sts.lbl_last   = (int'(idx_ff) + 1 == int'(len_ff)) || (int'(idx_ff) + 1 == MAX_RESULTS);
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      group_in     = group_ff;
      sc_in        = sc_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      phase_in     = phase_ff;
      prod_in      = prod_ff;
      held_in      = held_ff;
      pt_in        = pt_ff;
      kind_in      = kind_ff;
      lbyte_in     = lbyte_ff;
      trunc_in     = trunc_ff;
      last_in      = last_ff;
      p1x_in       = p1x_ff;
      p1y_in       = p1y_ff;
      p2x_in       = p2x_ff;
      p2y_in       = p2y_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_in  = csr_wdata;
            CSR_SCREEN_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.store_byte) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            len_in = len_ff + 1'b1;
         end
      end

      if (cmd.init_walk) begin
         idx_in   = '0;
         acc_in   = '0;
         neg_in   = 1'b0;
         phase_in = 1'b0;
      end

      if (cmd.parse_step) begin
         idx_in = idx_ff + 1'b1;
         if (is_dig) begin
            acc_in   = (acc_ff << 3) + (acc_ff << 1) + COORD_W'(dig_val);
            phase_in = 1'b1;
         end else if (is_sign) begin
            neg_in   = (rd_data_ff == CH_MINUS);
            phase_in = 1'b1;
         end
      end

      if (cmd.feed) begin
         held_in[group_ff] = coord_val;
         group_in          = group_ff + 1'b1;
         sc_in             = '0;
      end

      if (cmd.sc_mul) begin
         prod_in = COORD_W'(held_ff[sc_ff] * COORD_W'(scale_size));
      end

      if (cmd.sc_div) begin
         pt_in[sc_ff] = COORD_W'(recip_prod >> RECIP_SH);
         sc_in        = sc_ff + 1'b1;
      end

      if (cmd.load_box) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_BOX;
         lbyte_in     = '0;
         trunc_in     = 1'b0;
         last_in      = 1'b1;
         p1x_in       = pt_ff[0];
         p1y_in       = pt_ff[1];
         p2x_in       = pt_ff[2];
         p2y_in       = pt_ff[3];
      end

      if (cmd.load_lbl) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_LABEL;
         lbyte_in     = rd_data_ff;
         trunc_in     = trunc_flag;
         last_in      = sts.lbl_last;
         p1x_in       = '0;
         p1y_in       = '0;
         p2x_in       = '0;
         p2y_in       = '0;
         idx_in       = idx_ff + 1'b1;
      end

      if (cmd.clr_buf) begin
         len_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         group_ff     <= '0;
         sc_ff        <= '0;
         width_ff     <= SCREEN_WIDTH_RST;
         height_ff    <= SCREEN_HEIGHT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         group_ff     <= group_in;
         sc_ff        <= sc_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      acc_ff   <= acc_in;
      neg_ff   <= neg_in;
      phase_ff <= phase_in;
      prod_ff  <= prod_in;
      held_ff  <= held_in;
      pt_ff    <= pt_in;
      kind_ff  <= kind_in;
      lbyte_ff <= lbyte_in;
      trunc_ff <= trunc_in;
      last_ff  <= last_in;
      p1x_ff   <= p1x_in;
      p1y_ff   <= p1y_in;
      p2x_ff   <= p2x_in;
      p2y_ff   <= p2y_in;
   end

   // text buffer: one write port, one registered read port at the walk index
   always_ff @(posedge clock) begin
      if (cmd.store_byte && !full) begin
         text_mem[len_ff[ADDR_W-1:0]] <= req_in_byte;
      end
      if (int'(idx_ff) < TEXT_MAX) begin
         rd_data_ff <= text_mem[idx_ff[ADDR_W-1:0]];
      end
   end

   // first four bytes kept aside for tag matching
   always_ff @(posedge clock) begin
      if (cmd.store_byte && int'(len_ff) < 4) begin
         head_ff[len_ff[1:0]] <= req_in_byte;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = kind_ff;
   assign rsp_label_byte      = lbyte_ff;
   assign rsp_label_truncated = trunc_ff;
   assign rsp_last_of_run     = last_ff;
   assign rsp_point1_x        = p1x_ff;
   assign rsp_point1_y        = p1y_ff;
   assign rsp_point2_x        = p2x_ff;
   assign rsp_point2_y        = p2y_ff;

`ifndef SYNTH
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      int'(len_ff) <= TEXT_MAX)
      else $error("text length beyond buffer size");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> full)
      else $error("overflow flag set on a buffer that is not full");

   a_box_wraps: assert property (@(posedge clock) disable iff (reset)
      cmd.load_box |-> group_ff == 2'd0)
      else $error("box emitted with a group still open");

   a_box_last: assert property (@(posedge clock) disable iff (reset)
      cmd.load_lbl && sts.lbl_last |=> rsp_valid_ff && last_ff)
      else $error("last label byte not marked");
`endif

endmodule

// File: hw/rtl/tagged_box_text_parser_unit.sv
`timescale 1ns / 1ps
// Top level of the tagged box text parser.
// Depends on tbtp_pkg, tbtp_ctrl and tbtp_dp.
//
// Takes one text byte per transaction on req_ and emits label byte and box
// transactions on rsp_. An ordinary byte is stored in the buffer, an empty
// '<' is ignored and a '>' that ends a known tag drops the buffered tag. A
// '<' that flushes a label reads each buffered byte (buffer read, then result
// load), waiting whenever the result side stalls; a '<' inside a group feeds
// the group. A '>' that yields a number reads and parses the buffer bytes one
// by one until the scan runs to the end of the buffer or stops on another
// byte, then feeds the value. The token that closes a box then scales every
// coordinate (one shared 32x16 multiply and one reciprocal multiply per
// coordinate) and loads the result, waiting while the result side stalls.
// Throughput is set by the single read port of the text buffer and the
// shared scaling multiplier. A pending result does not block new input.
module tagged_box_text_parser_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_in_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_kind,
   output logic [7:0]                         rsp_label_byte,
   output logic                               rsp_label_truncated,
   output logic                               rsp_last_of_run,
   output logic [tbtp_pkg::COORD_W-1:0]       rsp_point1_x,
   output logic [tbtp_pkg::COORD_W-1:0]       rsp_point1_y,
   output logic [tbtp_pkg::COORD_W-1:0]       rsp_point2_x,
   output logic [tbtp_pkg::COORD_W-1:0]       rsp_point2_y,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tbtp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tbtp_pkg::CSR_W-1:0]         csr_wdata
);
   import tbtp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   tbtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tbtp_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_in_byte         (req_in_byte),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_label_byte      (rsp_label_byte),
      .rsp_label_truncated (rsp_label_truncated),
      .rsp_last_of_run     (rsp_last_of_run),
      .rsp_point1_x        (rsp_point1_x),
      .rsp_point1_y        (rsp_point1_y),
      .rsp_point2_x        (rsp_point2_x),
      .rsp_point2_y        (rsp_point2_y)
   );

endmodule
